// ===== hw/rtl/tscr_pkg.sv =====
`default_nettype none

package tscr_pkg;

  // Packing and length limits of the recoding
  localparam int unsigned MaxSymbols     = 256;
  localparam int unsigned SymbolsPerWord = 32;
  localparam int unsigned WordLimit      = 8;
  localparam int unsigned SymbolLimit    =
    (MaxSymbols < WordLimit * SymbolsPerWord) ? MaxSymbols : WordLimit * SymbolsPerWord;

  // Fixed field widths
  localparam int unsigned ScalarW = 128;
  localparam int unsigned WordW   = 64;
  localparam int unsigned CountW  = 6;
  localparam int unsigned LengthW = 9;

  // Chain symbols
  localparam logic [1:0] SymSubD   = 2'd0;  // d := (d-e)/2
  localparam logic [1:0] SymHalveD = 2'd1;  // d even, d := d/2
  localparam logic [1:0] SymSubE   = 2'd2;  // e := (e-d)/2
  localparam logic [1:0] SymHalveE = 2'd3;  // d odd, e := e/2

  // Result of one chain step
  typedef struct packed {
    logic [ScalarW-1:0] d;
    logic [ScalarW-1:0] e;
    logic [1:0]         sym;
  } step_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tscr_step.sv =====
`default_nettype none

// One chain step: parity test, compare, one subtract, halve
module tscr_step (
  input  wire logic [tscr_pkg::ScalarW-1:0] d_i,
  input  wire logic [tscr_pkg::ScalarW-1:0] e_i,
  output tscr_pkg::step_res_t               res_o
);

  logic                       ge;
  logic [tscr_pkg::ScalarW-1:0] big;
  logic [tscr_pkg::ScalarW-1:0] sml;
  logic [tscr_pkg::ScalarW-1:0] diff;

  // absolute difference through a single subtractor
  assign ge   = (d_i >= e_i);
  assign big  = ge ? d_i : e_i;
  assign sml  = ge ? e_i : d_i;
  assign diff = big - sml;

  always_comb begin
    res_o.d   = d_i;
    res_o.e   = e_i;
    res_o.sym = tscr_pkg::SymSubD;
    if (d_i[0] ^ e_i[0]) begin
      // parities differ: halve the even one
      if (d_i[0]) begin
        res_o.e   = e_i >> 1;
        res_o.sym = tscr_pkg::SymHalveE;
      end else begin
        res_o.d   = d_i >> 1;
        res_o.sym = tscr_pkg::SymHalveD;
      end
    end else if (ge) begin
      res_o.d   = diff >> 1;
      res_o.sym = tscr_pkg::SymSubD;
    end else begin
      res_o.e   = diff >> 1;
      res_o.sym = tscr_pkg::SymSubE;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/two_scalar_chain_recoding_unit.sv =====
// Items: a new item is accepted only in idle, after the last result word of the
//   previous one has been moved to the output register; an output stall holds it.
// Symbols: the shared step unit (128-bit compare, subtract, halve) makes one symbol a
//   cycle while no finished word waits for a free output register.
// Reset: asynchronous, active low; clears all registers and output valid.
`default_nettype none

module two_scalar_chain_recoding_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] first_low_i,
  input  wire logic [63:0] first_high_i,
  input  wire logic [63:0] second_low_i,
  input  wire logic [63:0] second_high_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      symbol_word_o,
  output logic [5:0]       symbols_in_word_o,
  output logic [8:0]       total_length_o,
  output logic             last_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                         state_q;
  logic [tscr_pkg::ScalarW-1:0]   d_q;
  logic [tscr_pkg::ScalarW-1:0]   e_q;
  logic [tscr_pkg::LengthW-1:0]   n_q;
  logic [tscr_pkg::CountW-1:0]    cnt_q;
  logic [tscr_pkg::WordW-1:0]     word_q;

  logic                           out_valid_q;
  logic [tscr_pkg::WordW-1:0]     out_word_q;
  logic [tscr_pkg::CountW-1:0]    out_cnt_q;
  logic [tscr_pkg::LengthW-1:0]   out_len_q;
  logic                           out_last_q;

  tscr_pkg::step_res_t            step;
  logic                           done;
  logic                           full;
  logic                           out_free;
  logic                           emit;

  tscr_step u_step (
    .d_i   (d_q),
    .e_i   (e_q),
    .res_o (step)
  );

  assign done     = (d_q == e_q) || (n_q == tscr_pkg::LengthW'(tscr_pkg::SymbolLimit));
  assign full     = (cnt_q == tscr_pkg::CountW'(tscr_pkg::SymbolsPerWord));
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == ST_RUN) && (done || full) && out_free;

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign symbol_word_o     = out_word_q;
  assign symbols_in_word_o = out_cnt_q;
  assign total_length_o    = out_len_q;
  assign last_o            = out_last_q;

  // sequencer, datapath registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      d_q         <= '0;
      e_q         <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_cnt_q   <= '0;
      out_len_q   <= '0;
      out_last_q  <= 1'b0;
      n_q         <= '0;
      cnt_q       <= '0;
    end else begin
      // output valid: set on emission, cleared once the word is taken
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            d_q     <= {first_high_i, first_low_i};
            e_q     <= {second_high_i, second_low_i};
            n_q     <= '0;
            cnt_q   <= '0;
            word_q  <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (done || full) begin
            // emit the pending word once the output register is free
            if (out_free) begin
              out_word_q  <= word_q;
              out_cnt_q   <= cnt_q;
              out_len_q   <= n_q;
              out_last_q  <= done;
              word_q      <= '0;
              cnt_q       <= '0;
              if (done) begin
                state_q <= ST_IDLE;
              end
            end
          end else begin
            d_q   <= step.d;
            e_q   <= step.e;
            word_q[{cnt_q[4:0], 1'b0} +: 2] <= step.sym;
            cnt_q <= cnt_q + 1'b1;
            n_q   <= n_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== dv/two_scalar_chain_recoding_unit_test.sv =====
`timescale 1ns / 100ps

module two_scalar_chain_recoding_unit_test;

  localparam int CycleLimit = 1000000;
  localparam int DirCount   = 22;
  localparam int RandCount  = 86;   // per idling phase, three phases
  localparam int TailCycles = 300;

  localparam logic [127:0] AllOnes = '1;
  localparam logic [127:0] TopBit  = 128'h1 << 127;
  localparam logic [127:0] LimbOne = 128'h1 << 64;

  // One result word of the recoding
  typedef struct packed {
    logic [63:0] word;
    logic [5:0]  cnt;
    logic [8:0]  total;
    logic        last;
  } chain_word_t;

  // One row of the directed table
  typedef struct packed {
    logic [127:0] d;
    logic [127:0] e;
    bit           typed;
    chain_word_t  exp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] first_low_i = '0;
  logic [63:0] first_high_i = '0;
  logic [63:0] second_low_i = '0;
  logic [63:0] second_high_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] symbol_word_o;
  logic [5:0]  symbols_in_word_o;
  logic [8:0]  total_length_o;
  logic        last_o;

  chain_word_t pending_words [$];
  int          failures = 0;
  int          send_idle_pct = 14;
  int          recv_idle_pct = 63;
  dir_row_t    dir_rows [DirCount];

  two_scalar_chain_recoding_unit u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .first_low_i,
    .first_high_i,
    .second_low_i,
    .second_high_i,
    .out_valid_o,
    .out_stall_i,
    .symbol_word_o,
    .symbols_in_word_o,
    .total_length_o,
    .last_o
  );

  always #4 clk_i = ~clk_i;

  // Chain recoding of one scalar pair, packed into result words
  function automatic void recode_chain(input logic [127:0] d_in, input logic [127:0] e_in);
    logic [127:0] d;
    logic [127:0] e;
    logic [1:0]   syms [256];
    int unsigned  n;
    int unsigned  words;
    int unsigned  base;
    int unsigned  cnt;
    chain_word_t  cw;
    d = d_in;
    e = e_in;
    n = 0;
    while (d != e && n < tscr_pkg::SymbolLimit) begin
      if (d[0] != e[0]) begin
        // parities differ: halve the even one
        if (d[0]) begin
          e = e >> 1;
          syms[n] = tscr_pkg::SymHalveE;
        end else begin
          d = d >> 1;
          syms[n] = tscr_pkg::SymHalveD;
        end
      end else if (d >= e) begin
        d = (d - e) >> 1;
        syms[n] = tscr_pkg::SymSubD;
      end else begin
        e = (e - d) >> 1;
        syms[n] = tscr_pkg::SymSubE;
      end
      n++;
    end
    words = (n == 0) ? 1 :
      (n + tscr_pkg::SymbolsPerWord - 1) / tscr_pkg::SymbolsPerWord;
    for (int unsigned w = 0; w < words; w++) begin
      base = w * tscr_pkg::SymbolsPerWord;
      cnt  = (n - base < tscr_pkg::SymbolsPerWord) ? n - base : tscr_pkg::SymbolsPerWord;
      if (n == 0) cnt = 0;
      cw.word = '0;
      for (int unsigned j = 0; j < cnt; j++) cw.word[2*j +: 2] = syms[base + j];
      cw.cnt   = 6'(cnt);
      cw.total = 9'(base + cnt);
      cw.last  = (w + 1 == words);
      pending_words.push_back(cw);
    end
  endfunction

  // Offer one pair; valid stays high straight into the next item unless a gap is drawn
  task automatic send_pair(input logic [127:0] d, input logic [127:0] e,
                           input bit typed, input chain_word_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    first_low_i   <= d[63:0];
    first_high_i  <= d[127:64];
    second_low_i  <= e[63:0];
    second_high_i <= e[127:64];
    do @(posedge clk_i); while (in_stall_o);
    if (typed) pending_words.push_back(exp);
    else recode_chain(d, e);
  endtask

  function automatic logic [127:0] rand_scalar();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Result side: random stall, check each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    chain_word_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word %h", symbol_word_o);
        failures++;
      end else begin
        want = pending_words.pop_front();
        if (symbol_word_o !== want.word) begin
          $error("symbol_word: expected %h, got %h", want.word, symbol_word_o);
          failures++;
        end
        if (symbols_in_word_o !== want.cnt) begin
          $error("symbols_in_word: expected %0d, got %0d", want.cnt, symbols_in_word_o);
          failures++;
        end
        if (total_length_o !== want.total) begin
          $error("total_length: expected %0d, got %0d", want.total, total_length_o);
          failures++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          failures++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Run limit
  initial begin
    for (int c = 0; c < CycleLimit; c++) @(posedge clk_i);
    $display("two_scalar_chain_recoding_unit test failed");
    $finish;
  end

  // Stimulus
  initial begin
    logic [127:0] d;
    logic [127:0] e;
    logic [127:0] mask;
    int unsigned  kind;
    int unsigned  nbits;

    // d, e, typed, {word, count, total, last}
    dir_rows = '{
      '{128'd0, 128'd0, 1'b1, '{64'd0, 6'd0, 9'd0, 1'b1}},            // equal, zero
      '{AllOnes, AllOnes, 1'b1, '{64'd0, 6'd0, 9'd0, 1'b1}},          // equal, all ones
      '{128'd2, 128'd1, 1'b1, '{64'd1, 6'd1, 9'd1, 1'b1}},            // d even: halve d
      '{128'd1, 128'd2, 1'b1, '{64'd3, 6'd1, 9'd1, 1'b1}},            // d odd: halve e
      '{128'd3, 128'd1, 1'b1, '{64'd0, 6'd1, 9'd1, 1'b1}},            // d >= e: subtract
      '{128'd1, 128'd3, 1'b1, '{64'd2, 6'd1, 9'd1, 1'b1}},            // d < e: subtract
      '{128'd1, 128'd0, 1'b0, '0},                                    // zero e runs to limit
      '{128'd0, 128'd1, 1'b0, '0},                                    // zero d runs to limit
      '{AllOnes, 128'd0, 1'b0, '0},
      '{128'd0, AllOnes, 1'b0, '0},
      '{AllOnes, AllOnes - 128'd1, 1'b0, '0},
      '{AllOnes, 128'd1, 1'b0, '0},
      '{128'd1, AllOnes, 1'b0, '0},
      '{{64'd0, 64'd5}, {64'd1, 64'd5}, 1'b0, '0},                    // difference has zero low limb
      '{{64'd1, 64'd5}, {64'd0, 64'd5}, 1'b0, '0},
      '{LimbOne, 128'd2, 1'b0, '0},                                   // borrow across limbs
      '{128'd2, LimbOne, 1'b0, '0},
      '{{64'hDEAD_BEEF_0000_0001, 64'h1234_5678_9ABC_DEF1},
        {64'hDEAD_BEEF_0000_0001, 64'h0FED_CBA9_8765_4323}, 1'b0, '0}, // same high limb
      '{{64'h0000_0000_0000_0007, 64'hFFFF_FFFF_FFFF_FFFF},
        {64'h8000_0000_0000_0003, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0}, // same low limb
      '{TopBit, TopBit | 128'd1, 1'b0, '0},
      '{AllOnes, TopBit, 1'b0, '0},
      '{{2{64'h5555_5555_5555_5555}}, {2{64'hAAAA_AAAA_AAAA_AAAA}}, 1'b0, '0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, under the first idling pattern
    for (int i = 0; i < DirCount; i++)
      send_pair(dir_rows[i].d, dir_rows[i].e, dir_rows[i].typed, dir_rows[i].exp);

    // random part in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 63 : 0;
      recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 14 : 0;
      for (int i = 0; i < RandCount; i++) begin
        kind = $urandom_range(99);
        d = rand_scalar();
        e = rand_scalar();
        if (kind < 50) begin
          // full width pair
        end else if (kind < 75) begin
          // narrow operands keep chains short
          nbits = $urandom_range(128, 1);
          mask  = (nbits == 128) ? AllOnes : ((128'd1 << nbits) - 128'd1);
          d = d & mask;
          e = e & mask;
        end else if (kind < 85) begin
          // close pair
          if ($urandom_range(1)) e = d ^ (128'd1 << $urandom_range(127));
          else e = d + 128'($urandom_range(16, 1));
        end else if (kind < 92) begin
          e = d;
        end else begin
          // a zero operand hits the symbol limit
          if ($urandom_range(1)) d = '0;
          else e = '0;
        end
        send_pair(d, e, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("two_scalar_chain_recoding_unit test passed");
    end else begin
      $display("two_scalar_chain_recoding_unit test failed");
    end
    $finish;
  end

endmodule
